@@ hdl/bsfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfd_pkg
// Shared constants and control types of the byte-stuffed frame deframer.
// ----------------------------------------------------------------------------
package bsfd_pkg;

   localparam int FRAME_MAX = 64;
   localparam int ADDR_W    = $clog2(FRAME_MAX);
   localparam int CNT_W     = $clog2(FRAME_MAX + 1);
   localparam int BYTE_W    = 8;
   localparam int CSR_IDX_W = 2;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_FLAG_BYTE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_BYTE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_MASK = 2'd2;

   localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'd126;
   localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd125;
   localparam logic [BYTE_W-1:0] MASK_RESET   = 8'd32;

   // commands from the controller to the datapath
   typedef struct packed {
      logic store_en;    // write the received byte at the fill address
      logic store_esc;   // XOR the escape mask onto the stored byte
      logic fill_clear;  // drop the current frame contents
      logic close;       // latch the frame length, clear fill, rewind read index
      logic rd_en;       // read the store at the read index
      logic rd_adv;      // step the read index
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic is_flag;
      logic is_esc;
      logic fill_full;
      logic fill_zero;
      logic rd_last;
   } status_type;

endpackage

@@ hdl/bsfd_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfd_dp
// Datapath: configuration registers, fill counter, frame store, read side.
// ----------------------------------------------------------------------------
module bsfd_dp
   import bsfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata,
   input  logic [BYTE_W-1:0]    rx_byte,
   input  cmd_type              cmd,
   output status_type           status,
   output logic [BYTE_W-1:0]    frame_byte,
   output logic [CNT_W-1:0]     frame_length
);

   logic [BYTE_W-1:0] flag_ff, flag_in;
   logic [BYTE_W-1:0] esc_ff, esc_in;
   logic [BYTE_W-1:0] mask_ff, mask_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [ADDR_W-1:0] rd_idx_ff, rd_idx_in;
   logic [BYTE_W-1:0] rd_data_ff;
   logic [BYTE_W-1:0] wr_data;
   logic [CNT_W-1:0]  rd_next;

   logic [BYTE_W-1:0] store_mem [FRAME_MAX];

   always_comb begin
      flag_in = flag_ff;
      esc_in  = esc_ff;
      mask_in = mask_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FLAG_BYTE:   flag_in = csr_wdata;
            CSR_ESCAPE_BYTE: esc_in  = csr_wdata;
            CSR_ESCAPE_MASK: mask_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.store_en) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (cmd.fill_clear || cmd.close) begin
         fill_in = '0;
      end
   end

   assign len_in    = cmd.close ? fill_ff : len_ff;
   assign rd_idx_in = cmd.close  ? '0 :
                      cmd.rd_adv ? rd_idx_ff + ADDR_W'(1) : rd_idx_ff;
   assign wr_data   = cmd.store_esc ? (rx_byte ^ mask_ff) : rx_byte;
   assign rd_next   = {1'b0, rd_idx_ff} + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= FLAG_RESET;
         esc_ff  <= ESCAPE_RESET;
         mask_ff <= MASK_RESET;
         fill_ff <= '0;
      end else begin
         flag_ff <= flag_in;
         esc_ff  <= esc_in;
         mask_ff <= mask_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff    <= len_in;
      rd_idx_ff <= rd_idx_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.store_en) begin
         store_mem[fill_ff[ADDR_W-1:0]] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= store_mem[rd_idx_ff];
      end
   end

   assign status.is_flag   = (rx_byte == flag_ff);
   assign status.is_esc    = (rx_byte == esc_ff);
   assign status.fill_full = (fill_ff >= CNT_W'(FRAME_MAX));
   assign status.fill_zero = (fill_ff == '0);
   assign status.rd_last   = (rd_next == len_ff);

   assign frame_byte   = rd_data_ff;
   assign frame_length = len_ff;

endmodule

@@ hdl/bsfd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfd_ctrl
// Controller: parser mode and the accept / read / show sequencer.
// ----------------------------------------------------------------------------
module bsfd_ctrl
   import bsfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   output logic       out_valid,
   input  logic       out_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_SHOW = 2'd2;

   localparam logic [1:0] MODE_HUNT  = 2'd0;
   localparam logic [1:0] MODE_FRAME = 2'd1;
   localparam logic [1:0] MODE_ESC   = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [1:0] mode_ff, mode_in;
   logic [1:0] eff_mode;
   logic       accept;

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_SHOW);
   assign accept    = in_valid && in_ready;
   // a full store drops the frame before the byte is looked at
   assign eff_mode  = status.fill_full ? MODE_HUNT : mode_ff;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.fill_clear = status.fill_full;
               case (eff_mode)
                  MODE_ESC: begin
                     cmd.store_en  = 1'b1;
                     cmd.store_esc = 1'b1;
                     mode_in       = MODE_FRAME;
                  end
                  MODE_FRAME: begin
                     if (status.is_esc) begin
                        mode_in = MODE_ESC;
                     end else if (status.is_flag) begin
                        if (!status.fill_zero) begin
                           cmd.close = 1'b1;
                           mode_in   = MODE_HUNT;
                           state_in  = ST_READ;
                        end
                     end else begin
                        cmd.store_en = 1'b1;
                     end
                  end
                  default: begin
                     mode_in = status.is_flag ? MODE_FRAME : MODE_HUNT;
                     if (status.is_flag) begin
                        cmd.fill_clear = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_SHOW;
         end
         ST_SHOW: begin
            if (out_ready) begin
               if (status.rd_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.rd_adv = 1'b1;
                  state_in   = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_HUNT;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

endmodule

@@ hdl/byte_stuffed_frame_deframer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stuffed_frame_deframer_top
// Recovers flag-delimited, escape-stuffed frames from a stream of raw bytes.
// ----------------------------------------------------------------------------
// A byte that does not close a frame leaves the block ready for the next byte.
// A closing flag starts the read-out: each word is first read from the store
// (READ), then shown (SHOW), and the input is held until the last word of the
// frame has been taken, output stalls included.
// Reset (synchronous, active high) returns the parser to hunting, empties the
// frame and restores the default flag, escape and mask; store contents stay.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_deframer_top
   import bsfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // received bytes
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] rx_byte
   // decoded frame words
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // [7:0] frame_byte, [14:8] frame_length
   output logic                 rsp_tlast,   // frame_last
   // configuration writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata
);

   cmd_type           cmd;
   status_type        status;
   logic [BYTE_W-1:0] frame_byte;
   logic [CNT_W-1:0]  frame_length;

   // sequencer: parser mode, accept and read-out control
   bsfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // registers, fill counter and the frame store
   bsfd_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rx_byte      (req_tdata),
      .cmd          (cmd),
      .status       (status),
      .frame_byte   (frame_byte),
      .frame_length (frame_length)
   );

   // pack the word; the top bit pads to a whole byte
   assign rsp_tdata = {1'b0, frame_length, frame_byte};
   assign rsp_tlast = status.rd_last;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte-stuffed frame deframer. A short table of
// hand-picked bytes under the default flag, escape and mask comes first.
// Random traffic follows under several register settings: mostly well-formed
// stuffed frames, plus line noise, dangling escapes, unclosed frames and
// a frame long enough to overflow the store. A bit-level parser model predicts
// the random-traffic words and the ROW_PREDICT rows. The sender runs in bursts
// and the receiver stalls on its own pattern; one long hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_top
   import bsfd_pkg::*;
();

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;    // read-out is finished once its last word is out
   localparam int TAIL_CYCLES   = 24;   // watch for stray words after the last one
   localparam int LONG_HOLD     = 300;  // receiver hold-off that fills the block up
   localparam int HOLD_AFTER    = 3;    // words to see before the long hold-off starts

   // the register port has one spare index, which the block must ignore
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // parser states of the model
   typedef enum logic [1:0] {
      HUNTING   = 2'd0,
      IN_FRAME  = 2'd1,
      AFTER_ESC = 2'd2
   } parse_mode_type;

   // one decoded word as it should leave the block
   typedef struct packed {
      logic [7:0] data;
      logic [6:0] length;
      logic       last;
   } frame_word_type;

   // how a row of the directed table is checked
   typedef enum logic [1:0] {
      ROW_QUIET   = 2'd0,   // the byte yields no word
      ROW_SINGLE  = 2'd1,   // the byte closes a one-byte frame holding single
      ROW_PREDICT = 2'd2    // the model works the words out
   } row_kind_type;

   typedef struct packed {
      logic [7:0]   rx;
      row_kind_type kind;
      logic [7:0]   single;
   } stim_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [7:0] frame_byte, [14:8] frame_length
   logic        rsp_tlast;            // frame_last
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [BYTE_W-1:0]    csr_wdata = '0;

   // model state and its copy of the registers
   parse_mode_type pm_mode   = HUNTING;
   int             pm_fill   = 0;
   logic [7:0]     pm_store [FRAME_MAX];
   logic [7:0]     pm_flag   = FLAG_RESET;
   logic [7:0]     pm_escape = ESCAPE_RESET;
   logic [7:0]     pm_mask   = MASK_RESET;

   frame_word_type frame_words_due [$];
   int             mismatch_count = 0;
   int             words_seen     = 0;
   int             cycle_count    = 0;
   int             phase_items    = 0;   // bytes of this phase that the parser acted on
   int             burst_left     = 0;

   // Default flag 7E, escape 7D, mask 20.
   stim_row_type directed_rows [0:25] = '{
      '{8'h00, ROW_QUIET,   8'h00},   // noise while hunting
      '{8'h7D, ROW_QUIET,   8'h00},   // escape while hunting is noise too
      '{8'h7E, ROW_QUIET,   8'h00},   // open
      '{8'h7E, ROW_QUIET,   8'h00},   // repeated flag on an empty frame
      '{8'h00, ROW_QUIET,   8'h00},
      '{8'h7E, ROW_SINGLE,  8'h00},   // lowest byte value
      '{8'h7E, ROW_QUIET,   8'h00},
      '{8'hFF, ROW_QUIET,   8'h00},
      '{8'h7E, ROW_SINGLE,  8'hFF},   // highest byte value
      '{8'h7E, ROW_QUIET,   8'h00},
      '{8'h7D, ROW_QUIET,   8'h00},
      '{8'h5E, ROW_QUIET,   8'h00},   // stuffed flag
      '{8'h7D, ROW_QUIET,   8'h00},
      '{8'h7E, ROW_QUIET,   8'h00},   // raw flag after an escape is payload
      '{8'h7D, ROW_QUIET,   8'h00},
      '{8'h7D, ROW_QUIET,   8'h00},   // raw escape after an escape is payload
      '{8'hA5, ROW_QUIET,   8'h00},
      '{8'h7E, ROW_PREDICT, 8'h00},
      '{8'h7E, ROW_QUIET,   8'h00},
      '{8'h7D, ROW_QUIET,   8'h00},
      '{8'hFF, ROW_QUIET,   8'h00},
      '{8'h7E, ROW_SINGLE,  8'hDF},   // escaped FF comes back as FF ^ 20
      '{8'h7E, ROW_QUIET,   8'h00},
      '{8'h01, ROW_QUIET,   8'h00},
      '{8'h80, ROW_QUIET,   8'h00},
      '{8'h7E, ROW_PREDICT, 8'h00}
   };

   byte_stuffed_frame_deframer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Parser model
   // ------------------------------------------------------------------------

   // Append one payload byte; a full store takes nothing more.
   function automatic void stash_byte(input logic [7:0] b);
      if (pm_fill < FRAME_MAX) begin
         pm_store[pm_fill[ADDR_W-1:0]] = b;
         pm_fill++;
      end
   endfunction

   // Advance the model by one received byte and append the words it releases.
   // Returns 1 when the byte left the parser untouched (noise while hunting).
   function automatic bit deframe_byte(input logic [7:0] rx,
                                       ref frame_word_type words [$]);
      bit             dropped = 1'b0;
      bit             untouched = 1'b0;
      frame_word_type w;
      // a byte meeting a full store drops the frame, then is seen while hunting
      if (pm_fill >= FRAME_MAX) begin
         pm_mode = HUNTING;
         pm_fill = 0;
         dropped = 1'b1;
      end
      case (pm_mode)
         AFTER_ESC: begin
            stash_byte(rx ^ pm_mask);
            pm_mode = IN_FRAME;
         end
         IN_FRAME: begin
            // escape wins over flag when both registers hold the same value
            if (rx == pm_escape) begin
               pm_mode = AFTER_ESC;
            end else if (rx == pm_flag) begin
               if (pm_fill != 0) begin
                  for (int k = 0; k < pm_fill; k++) begin
                     w.data   = pm_store[k[ADDR_W-1:0]];
                     w.length = pm_fill[6:0];
                     w.last   = (k == pm_fill - 1);
                     words.push_back(w);
                  end
                  pm_mode = HUNTING;
               end
               pm_fill = 0;
            end else begin
               stash_byte(rx);
            end
         end
         default: begin
            pm_mode = HUNTING;
            if (rx == pm_flag) begin
               pm_mode = IN_FRAME;
               pm_fill = 0;
            end else begin
               untouched = !dropped;
            end
         end
      endcase
      return untouched;
   endfunction

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------

   // Offer one byte, opening a random gap between bursts, and hold until taken.
   // Valid is left high so that the next byte of the burst follows at once.
   task automatic offer_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   // Offer one byte and queue whatever the model says it releases.
   task automatic put_byte(input logic [7:0] b);
      frame_word_type words [$];
      offer_byte(b);
      if (!deframe_byte(b, words)) phase_items++;
      foreach (words[k]) frame_words_due.push_back(words[k]);
   endtask

   // Drop valid, let every outstanding word drain, then let the block settle.
   task automatic settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (frame_words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_FLAG_BYTE:   pm_flag   = val;
         CSR_ESCAPE_BYTE: pm_escape = val;
         CSR_ESCAPE_MASK: pm_mask   = val;
         default: ;
      endcase
   endtask

   // Program all three registers back to back; optionally poke the spare index.
   task automatic set_config(input logic [7:0] flag_val, input logic [7:0] esc_val,
                             input logic [7:0] mask_val, input bit poke_spare);
      write_reg(CSR_FLAG_BYTE,   flag_val);
      write_reg(CSR_ESCAPE_BYTE, esc_val);
      write_reg(CSR_ESCAPE_MASK, mask_val);
      if (poke_spare) write_reg(CSR_SPARE, 8'hFF);
      csr_we <= 1'b0;
   endtask

   // Raw payload of n bytes with no stuffing needed, so it can outgrow the store.
   task automatic send_long_frame(input int n);
      logic [7:0] b;
      put_byte(pm_flag);
      repeat (n) begin
         do b = 8'($urandom_range(0, 255)); while (b == pm_flag || b == pm_escape);
         put_byte(b);
      end
      put_byte(pm_flag);
   endtask

   // Random traffic until the parser has acted on roughly budget bytes.
   task automatic send_random_traffic(input int budget);
      int         pick;
      int         n;
      logic [7:0] b;
      phase_items = 0;
      while (phase_items < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            // well-formed frame, stuffed the way a real sender would
            put_byte(pm_flag);
            if ($urandom_range(0, 7) == 0) put_byte(pm_flag);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            repeat (n) begin
               b = 8'($urandom_range(0, 255));
               if (b == pm_flag || b == pm_escape || $urandom_range(0, 9) == 0) begin
                  put_byte(pm_escape);
                  put_byte(b ^ pm_mask);
               end else begin
                  put_byte(b);
               end
            end
            put_byte(pm_flag);
         end else if (pick < 85) begin
            // line noise
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
         end else if (pick < 92) begin
            // escape right before the flag: the flag becomes payload, frame stays open
            put_byte(pm_flag);
            put_byte(8'($urandom_range(0, 255)));
            put_byte(pm_escape);
            put_byte(pm_flag);
         end else begin
            // frame left open; the next opening flag closes it
            put_byte(pm_flag);
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      frame_word_type words [$];
      frame_word_type typed;
      logic [7:0]     flag_val;
      logic [7:0]     esc_val;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table under the reset values of the registers.
      foreach (directed_rows[r]) begin
         offer_byte(directed_rows[r].rx);
         words.delete();
         void'(deframe_byte(directed_rows[r].rx, words));
         case (directed_rows[r].kind)
            ROW_SINGLE: begin
               typed.data   = directed_rows[r].single;
               typed.length = 7'd1;
               typed.last   = 1'b1;
               frame_words_due.push_back(typed);
            end
            ROW_PREDICT: begin
               foreach (words[k]) frame_words_due.push_back(words[k]);
            end
            default: ;
         endcase
      end
      settle();

      // Extremes: flag at the bottom, escape and mask at the top.
      set_config(8'h00, 8'hFF, 8'hFF, 1'b0);
      send_random_traffic(12);
      settle();

      // Extremes the other way round; a zero mask leaves escaped bytes as sent.
      set_config(8'hFF, 8'h00, 8'h00, 1'b0);
      send_random_traffic(12);
      settle();

      // Flag equal to escape: inside a frame it always escapes, so frames only
      // end by overflowing the store.
      set_config(8'h55, 8'h55, 8'h3C, 1'b0);
      send_random_traffic(10);
      settle();

      // Random distinct flag and escape; the closing flag meets a full store.
      flag_val = 8'($urandom_range(0, 255));
      do esc_val = 8'($urandom_range(0, 255)); while (esc_val == flag_val);
      set_config(flag_val, esc_val, 8'($urandom_range(0, 255)), 1'b0);
      send_random_traffic(10);
      send_long_frame(FRAME_MAX);
      settle();

      // Back to the defaults; the spare index must change nothing.
      set_config(FLAG_RESET, ESCAPE_RESET, MASK_RESET, 1'b1);
      send_random_traffic(10);
      settle();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("byte_stuffed_frame_deframer_top: match");
      end else begin
         $display("byte_stuffed_frame_deframer_top: mismatch");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Receiver: stall pattern of its own, plus one long hold-off as soon as the
   // first few words are out, so that the read-out backs up and the input is
   // held while the directed table is still being sent.
   // ------------------------------------------------------------------------
   initial begin : rsp_stall_pattern
      int  style;
      int  stretch;
      bit  long_hold_done;
      long_hold_done = 1'b0;
      forever begin
         style   = $urandom_range(0, 3);
         stretch = $urandom_range(10, 60);
         repeat (stretch) begin
            @(posedge clock);
            if (!long_hold_done && words_seen >= HOLD_AFTER) begin
               long_hold_done = 1'b1;
               rsp_tready <= 1'b0;
               repeat (LONG_HOLD) @(posedge clock);
            end
            case (style)
               0: rsp_tready <= 1'b1;                             // no stalls
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);      // mostly stalled
               default: rsp_tready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Checker: compare each accepted word with the oldest expectation.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      frame_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_seen++;
         if (frame_words_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected word, expected none, got byte %02h length %0d last %0b",
                     $time, rsp_tdata[7:0], rsp_tdata[14:8], rsp_tlast);
         end else begin
            want = frame_words_due.pop_front();
            if (rsp_tdata[7:0] !== want.data) begin
               mismatch_count++;
               $display("%0t: frame_byte expected %02h, got %02h",
                        $time, want.data, rsp_tdata[7:0]);
            end
            if (rsp_tdata[14:8] !== want.length) begin
               mismatch_count++;
               $display("%0t: frame_length expected %0d, got %0d",
                        $time, want.length, rsp_tdata[14:8]);
            end
            if (rsp_tlast !== want.last) begin
               mismatch_count++;
               $display("%0t: frame_last expected %0b, got %0b",
                        $time, want.last, rsp_tlast);
            end
         end
      end
   end

   // Watchdog: give up long after the slowest correct run would have finished.
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("byte_stuffed_frame_deframer_top: mismatch");
         $finish;
      end
   end

endmodule

@@ sim.f @@
hdl/bsfd_pkg.sv
hdl/bsfd_dp.sv
hdl/bsfd_ctrl.sv
hdl/byte_stuffed_frame_deframer_top.sv
dv/tb_top.sv
